FILE: hdl/rkh_pkg.sv
// Shared constants and widths for the recurring key hour qualifier.
// No dependencies; imported by rkh_div and the top level.
package rkh_pkg;

  localparam int DEF_MAX_ENTRIES = 16;
  localparam int DEF_MAX_WINDOW  = 16;
  localparam int DEF_FP_BITS     = 64;

  localparam int SEC_W    = 32;
  localparam int HOUR_W   = 21;
  localparam int CFG_W    = 5;
  localparam int CFG_AW   = 2;
  localparam int SEC_PER_HOUR = 3600;

  // seconds / 3600 = (seconds >> 4) / 225, taken as a reciprocal multiply
  localparam int HOUR_SHIFT  = 4;
  localparam int RECIP_W     = 29;
  localparam int RECIP_SHIFT = 36;
  localparam logic [RECIP_W-1:0] HOUR_RECIP = 29'd305419897;

  localparam logic [CFG_AW-1:0] REG_WINDOW = 2'd0;
  localparam logic [CFG_AW-1:0] REG_MINHRS = 2'd1;
  localparam logic [CFG_AW-1:0] REG_CANDS  = 2'd2;

endpackage

FILE: hdl/rkh_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module rkh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/rkh_div.sv
// Divide of seconds by seconds-per-hour through a reciprocal multiply.
// Depends on rkh_pkg.
module rkh_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [rkh_pkg::SEC_W-1:0] seconds,
  output logic                      done,
  output logic [rkh_pkg::HOUR_W-1:0] hour
);
  import rkh_pkg::*;

  localparam int XW = SEC_W - HOUR_SHIFT;
  localparam int PW = XW + RECIP_W;

  logic [XW-1:0] x_r, x_nxt;
  logic [PW-1:0] prod_r, prod_nxt;
  logic          pend_r, pend_nxt;
  logic          done_r, done_nxt;

  always_comb begin
    x_nxt    = x_r;
    prod_nxt = prod_r;
    pend_nxt = pend_r;
    done_nxt = done_r;
    if (start) begin
      x_nxt    = seconds[SEC_W-1:HOUR_SHIFT];
      pend_nxt = 1'b1;
      done_nxt = 1'b0;
    end else if (pend_r) begin
      prod_nxt = PW'(x_r) * PW'(HOUR_RECIP);
      pend_nxt = 1'b0;
      done_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      pend_r <= pend_nxt;
      done_r <= done_nxt;
    end
    x_r    <= x_nxt;
    prod_r <= prod_nxt;
  end

  assign done = done_r;
  assign hour = prod_r[RECIP_SHIFT +: HOUR_W];

endmodule

FILE: hdl/recurring_key_hour_qualifier_unit.sv
// Top level of the recurring key hour qualifier: sequencer, entry table, hour lists.
// Depends on rkh_pkg, rkh_div and rkh_ram.
//
//   channel | direction | contents
//   in_     | slave     | tdata: fingerprint, unix_seconds
//   out_    | master    | tdata: newly_qualified
//   cfg_    | write     | window length, distinct-hour threshold, entries in use
//
// An item runs a scan over the candidates in use, stopping at a hit, with the divide
// running under it, then takes the hour, compacts the stored hours and ends with a
// write-back, which waits while an earlier result has not yet been taken.
// in_tready is high only while idle; the result register holds until taken.
// rst_n is synchronous; entry contents need no clearing pass.
module recurring_key_hour_qualifier_unit #(
  parameter int MAX_ENTRIES = rkh_pkg::DEF_MAX_ENTRIES,
  parameter int MAX_WINDOW  = rkh_pkg::DEF_MAX_WINDOW,
  parameter int FP_BITS     = rkh_pkg::DEF_FP_BITS
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // fingerprint [FP_BITS-1:0], unix_seconds above it, zero fill to bytes
  input  logic [((FP_BITS + rkh_pkg::SEC_W + 7) / 8) * 8 - 1:0] in_tdata,
  output logic out_tvalid,
  input  logic out_tready,
  // newly_qualified [0], zero fill
  output logic [7:0] out_tdata,
  input  logic cfg_we,
  input  logic [rkh_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [rkh_pkg::CFG_W-1:0]  cfg_wdata
);
  import rkh_pkg::*;

  localparam int EW   = MAX_ENTRIES > 1 ? $clog2(MAX_ENTRIES) : 1;
  localparam int IW   = $clog2(MAX_ENTRIES + 1);
  localparam int CNW  = $clog2(MAX_WINDOW + 1);
  localparam int LD   = MAX_ENTRIES * MAX_WINDOW;
  localparam int LAW  = LD > 1 ? $clog2(LD) : 1;
  localparam int ENTW = FP_BITS + CNW + HOUR_W;
  localparam int CMPW = 10;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SRD  = 3'd1;
  localparam logic [2:0] S_SCHK = 3'd2;
  localparam logic [2:0] S_DIVW = 3'd3;
  localparam logic [2:0] S_CRD  = 3'd4;
  localparam logic [2:0] S_CCHK = 3'd5;
  localparam logic [2:0] S_ADD  = 3'd6;

  logic [2:0]         state_r, state_nxt;
  logic [CFG_W-1:0]   win_r, win_nxt, min_r, min_nxt;
  logic [IW-1:0]      cands_r, cands_nxt;
  logic [MAX_ENTRIES-1:0] valid_r, valid_nxt, fired_r, fired_nxt;
  logic [FP_BITS-1:0] key_r, key_nxt;
  logic [IW-1:0]      idx_r, idx_nxt;
  logic               hit_r, hit_nxt, free_f_r, free_f_nxt, lru_f_r, lru_f_nxt;
  logic [EW-1:0]      slot_r, slot_nxt, free_r, free_nxt, lru_r, lru_nxt;
  logic [HOUR_W-1:0]  lru_h_r, lru_h_nxt, newest_r, newest_nxt, start_r, start_nxt;
  logic [CNW-1:0]     cnt_r, cnt_nxt, rd_r, rd_nxt, wr_r, wr_nxt;
  logic               has_r, has_nxt;
  logic               ov_r, ov_nxt, oq_r, oq_nxt;

  logic               div_start, div_done;
  logic [HOUR_W-1:0]  hour;
  logic               ent_we;
  logic [ENTW-1:0]    ent_wdata, ent_rdata;
  logic [EW-1:0]      ent_raddr;
  logic [FP_BITS-1:0] rd_key;
  logic [CNW-1:0]     rd_cnt;
  logic [HOUR_W-1:0]  rd_new;
  logic               lst_we;
  logic [LAW-1:0]     lst_waddr, lst_raddr, base;
  logic [HOUR_W-1:0]  lst_wdata, lst_rdata;
  logic [HOUR_W-1:0]  span;
  logic [CNW-1:0]     fin_cnt;
  logic [CMPW-1:0]    wv;

  assign {rd_key, rd_cnt, rd_new} = ent_rdata;
  assign base = LAW'(slot_r * MAX_WINDOW);
  assign span = HOUR_W'(win_r - 1'b1);
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = ov_r;
  assign out_tdata  = {7'd0, oq_r};
  assign div_start  = in_tvalid && in_tready;

  rkh_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start),
    .seconds(in_tdata[FP_BITS +: SEC_W]), .done(div_done), .hour(hour)
  );

  rkh_ram #(.WIDTH(ENTW), .DEPTH(MAX_ENTRIES)) u_ent (
    .clk(clk), .we(ent_we), .waddr(slot_r), .wdata(ent_wdata),
    .raddr(ent_raddr), .rdata(ent_rdata)
  );

  rkh_ram #(.WIDTH(HOUR_W), .DEPTH(LD)) u_lst (
    .clk(clk), .we(lst_we), .waddr(lst_waddr), .wdata(lst_wdata),
    .raddr(lst_raddr), .rdata(lst_rdata)
  );

  always_comb begin
    win_nxt = win_r;
    min_nxt = min_r;
    cands_nxt = cands_r;
    if (cfg_we) begin
      case (cfg_addr)
        REG_WINDOW: begin
          if (cfg_wdata == '0) begin
            win_nxt = CFG_W'(1);
          end else if (CMPW'(cfg_wdata) > CMPW'(MAX_WINDOW)) begin
            win_nxt = CFG_W'(MAX_WINDOW);
          end else begin
            win_nxt = cfg_wdata;
          end
          if (min_r > win_nxt) begin
            min_nxt = win_nxt;
          end
        end
        REG_MINHRS: begin
          if (cfg_wdata == '0) begin
            min_nxt = CFG_W'(1);
          end else if (cfg_wdata > win_r) begin
            min_nxt = win_r;
          end else begin
            min_nxt = cfg_wdata;
          end
        end
        REG_CANDS: begin
          if (cfg_wdata == '0 || CMPW'(cfg_wdata) > CMPW'(MAX_ENTRIES)) begin
            cands_nxt = IW'(MAX_ENTRIES);
          end else begin
            cands_nxt = IW'(cfg_wdata);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    valid_nxt = valid_r;
    fired_nxt = fired_r;
    key_nxt = key_r;
    idx_nxt = idx_r;
    hit_nxt = hit_r;
    free_f_nxt = free_f_r;
    lru_f_nxt = lru_f_r;
    slot_nxt = slot_r;
    free_nxt = free_r;
    lru_nxt = lru_r;
    lru_h_nxt = lru_h_r;
    newest_nxt = newest_r;
    start_nxt = start_r;
    cnt_nxt = cnt_r;
    rd_nxt = rd_r;
    wr_nxt = wr_r;
    has_nxt = has_r;
    ov_nxt = ov_r;
    oq_nxt = oq_r;
    ent_raddr = idx_r[EW-1:0];
    ent_we = 1'b0;
    ent_wdata = {key_r, cnt_r, newest_r};
    lst_we = 1'b0;
    lst_waddr = LAW'(base + LAW'(wr_r));
    lst_wdata = lst_rdata;
    lst_raddr = LAW'(base + LAW'(rd_r));
    fin_cnt = wr_r;
    wv = CMPW'(wr_r);

    if (ov_r && out_tready) begin
      ov_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (div_start) begin
          key_nxt = in_tdata[FP_BITS-1:0];
          idx_nxt = '0;
          hit_nxt = 1'b0;
          free_f_nxt = 1'b0;
          lru_f_nxt = 1'b0;
          state_nxt = S_SRD;
        end
      end
      S_SRD: begin
        if (idx_r == cands_r) begin
          state_nxt = S_DIVW;
        end else begin
          state_nxt = S_SCHK;
        end
      end
      S_SCHK: begin
        if (valid_r[idx_r[EW-1:0]] && rd_key == key_r) begin
          hit_nxt = 1'b1;
          slot_nxt = idx_r[EW-1:0];
          cnt_nxt = rd_cnt;
          newest_nxt = rd_new;
          state_nxt = S_DIVW;
        end else begin
          if (!valid_r[idx_r[EW-1:0]]) begin
            if (!free_f_r) begin
              free_f_nxt = 1'b1;
              free_nxt = idx_r[EW-1:0];
            end
          end else if (!lru_f_r || rd_new < lru_h_r) begin
            lru_f_nxt = 1'b1;
            lru_nxt = idx_r[EW-1:0];
            lru_h_nxt = rd_new;
          end
          idx_nxt = idx_r + 1'b1;
          state_nxt = S_SRD;
        end
      end
      S_DIVW: begin
        if (div_done) begin
          if (!hit_r) begin
            slot_nxt = free_f_r ? free_r : lru_r;
            cnt_nxt = '0;
            newest_nxt = hour;
            valid_nxt[slot_nxt] = 1'b1;
            fired_nxt[slot_nxt] = 1'b0;
          end
          start_nxt = (hour >= span) ? HOUR_W'(hour - span) : '0;
          rd_nxt = '0;
          wr_nxt = '0;
          has_nxt = 1'b0;
          state_nxt = S_CRD;
        end
      end
      S_CRD: begin
        if (rd_r == cnt_r) begin
          state_nxt = S_ADD;
        end else begin
          state_nxt = S_CCHK;
        end
      end
      S_CCHK: begin
        if (lst_rdata >= start_r) begin
          if (lst_rdata == hour) begin
            has_nxt = 1'b1;
          end
          lst_we = 1'b1;
          wr_nxt = wr_r + 1'b1;
        end
        rd_nxt = rd_r + 1'b1;
        state_nxt = S_CRD;
      end
      S_ADD: begin
        if (!ov_r || out_tready) begin
          if (!has_r && wv < CMPW'(MAX_WINDOW)) begin
            lst_we = 1'b1;
            lst_wdata = hour;
            fin_cnt = wr_r + 1'b1;
          end
          cnt_nxt = fin_cnt;
          if (hour > newest_r) begin
            newest_nxt = hour;
          end
          ent_we = 1'b1;
          ent_wdata = {key_r, fin_cnt, newest_nxt};
          ov_nxt = 1'b1;
          oq_nxt = 1'b0;
          if (!fired_r[slot_r] && CMPW'(fin_cnt) >= CMPW'(min_r)) begin
            fired_nxt[slot_r] = 1'b1;
            oq_nxt = 1'b1;
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      win_r   <= CFG_W'(MAX_WINDOW < 16 ? MAX_WINDOW : 16);
      min_r   <= CFG_W'(MAX_WINDOW < 4 ? MAX_WINDOW : 4);
      cands_r <= IW'(MAX_ENTRIES < 16 ? MAX_ENTRIES : 16);
      valid_r <= '0;
      fired_r <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      win_r   <= win_nxt;
      min_r   <= min_nxt;
      cands_r <= cands_nxt;
      valid_r <= valid_nxt;
      fired_r <= fired_nxt;
      ov_r    <= ov_nxt;
    end
    key_r    <= key_nxt;
    idx_r    <= idx_nxt;
    hit_r    <= hit_nxt;
    free_f_r <= free_f_nxt;
    lru_f_r  <= lru_f_nxt;
    slot_r   <= slot_nxt;
    free_r   <= free_nxt;
    lru_r    <= lru_nxt;
    lru_h_r  <= lru_h_nxt;
    newest_r <= newest_nxt;
    start_r  <= start_nxt;
    cnt_r    <= cnt_nxt;
    rd_r     <= rd_nxt;
    wr_r     <= wr_nxt;
    has_r    <= has_nxt;
    oq_r     <= oq_nxt;
  end

endmodule
